@@ rtl/core/lrs_pkg.sv @@
// Shared types, codes and constants for the link reconnect supervisor.
package lrs_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;

  // Millisecond constants
  localparam logic [31:0] STEP_MS     = 32'd100;
  localparam logic [31:0] HOLD_MS     = 32'd3000;
  localparam logic [31:0] FORCE_MS    = 32'd600000;
  localparam logic [31:0] IDLE_OFF_MS = 32'd30000;
  localparam logic [31:0] BACKOFF1_MS = 32'd1000;
  localparam logic [31:0] BACKOFF2_MS = 32'd5000;
  localparam logic [31:0] BACKOFF3_MS = 32'd15000;
  localparam logic [31:0] REJECT_MS   = 32'd1000;

  localparam logic [15:0] BACKOFF1_MAX = 16'd5;
  localparam logic [15:0] BACKOFF2_MAX = 16'd10;

  // Configuration
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned DELAY_MS_W  = 22;
  localparam int unsigned MS_PER_S    = 1000;
  localparam int unsigned AP_DELAY_RST = 60;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    FN_TICK,
    FN_LINK_LOST,
    FN_GOT_ADDR,
    FN_CLIENT_JOIN,
    FN_CLIENT_LEAVE,
    FN_REJECTED,
    FN_CREDS,
    FN_AP_REQ
  } lrs_func_e;

  typedef enum logic [1:0] {
    AP_NONE = 2'd0,
    AP_ON   = 2'd1,
    AP_OFF  = 2'd2
  } lrs_ap_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AP_DELAY,
    CFG_BUTTON_EN
  } lrs_cfg_idx_e;

  typedef struct packed {
    lrs_func_e  func;
    logic       button_pressed;
    logic       op_busy;
    logic [7:0] disconnect_reason;
    logic       ap_request_on;
    logic       creds_present;
  } lrs_item_t;

  typedef struct packed {
    logic        request_refused;
    logic [7:0]  drop_reason;
    logic [15:0] retry_count;
    logic [7:0]  client_count;
    logic        ap_active;
    logic        link_up;
    lrs_ap_cmd_e cmd_ap;
    logic        cmd_connect;
  } lrs_result_t;

  typedef struct packed {
    logic [DELAY_MS_W-1:0] delay_ms;
    logic                  button_en;
  } lrs_cfg_t;

endpackage

@@ rtl/core/lrs_in_stage.sv @@
// Input register: unpacks the slave beat and holds it until the core takes it.
module lrs_in_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lrs_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [lrs_pkg::IN_USER_W-1:0] s_axis_tuser,
  input  logic                          take_i,
  output logic                          valid_o,
  output lrs_pkg::lrs_item_t            item_o
);
  import lrs_pkg::*;

  logic      valid_q;
  lrs_item_t item_q;
  lrs_item_t item_d;

  assign s_axis_tready = !valid_q || take_i;

  always_comb begin
    item_d.func              = lrs_func_e'(s_axis_tuser);
    item_d.button_pressed    = s_axis_tdata[0];
    item_d.op_busy           = s_axis_tdata[1];
    item_d.disconnect_reason = s_axis_tdata[9:2];
    item_d.ap_request_on     = s_axis_tdata[10];
    item_d.creds_present     = s_axis_tdata[11];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/core/lrs_core.sv @@
// Supervisor state and single-pass event decision logic.
module lrs_core #(
  parameter int unsigned TIME_BITS = lrs_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  lrs_pkg::lrs_item_t   item_i,
  input  lrs_pkg::lrs_cfg_t    cfg_i,
  output lrs_pkg::lrs_result_t result_o
);
  import lrs_pkg::*;

  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned CW = (TW > 32) ? TW : 32;

  function automatic logic passed_f(input logic [TW-1:0] now, input logic [TW-1:0] since,
                                    input logic [CW-1:0] ms);
    logic [TW-1:0] diff;
    diff = now - since;
    return CW'(diff) >= ms;
  endfunction

  function automatic logic due_f(input logic [TW-1:0] now, input logic [TW-1:0] deadline);
    logic [TW-1:0] diff;
    diff = now - deadline;
    return !diff[TW-1];
  endfunction

  logic [TW-1:0] tick_q, tick_d, down_since_q, down_since_d, up_since_q, up_since_d;
  logic [TW-1:0] next_retry_q, next_retry_d, forced_until_q, forced_until_d;
  logic [TW-1:0] press_start_q, press_start_d, tick_next, wait_ms;
  logic          link_q, link_d, connecting_q, connecting_d, creds_q, creds_d;
  logic          ap_on_q, ap_on_d, forced_q, forced_d, pressing_q, pressing_d;
  logic          press_done_q, press_done_d;
  logic [7:0]    clients_q, clients_d, reason_q, reason_d;
  logic [15:0]   retries_q, retries_d, retries_inc;
  logic          cmd_connect, refused;
  lrs_ap_cmd_e   cmd_ap;

  assign tick_next   = tick_q + TW'(STEP_MS);
  assign retries_inc = (retries_q != 16'hFFFF) ? retries_q + 16'd1 : retries_q;

  always_comb begin
    if (retries_inc <= BACKOFF1_MAX) begin
      wait_ms = TW'(BACKOFF1_MS);
    end else if (retries_inc <= BACKOFF2_MAX) begin
      wait_ms = TW'(BACKOFF2_MS);
    end else begin
      wait_ms = TW'(BACKOFF3_MS);
    end
  end

  always_comb begin
    tick_d         = tick_q;
    down_since_d   = down_since_q;
    up_since_d     = up_since_q;
    next_retry_d   = next_retry_q;
    forced_until_d = forced_until_q;
    press_start_d  = press_start_q;
    link_d         = link_q;
    connecting_d   = connecting_q;
    creds_d        = creds_q;
    ap_on_d        = ap_on_q;
    forced_d       = forced_q;
    pressing_d     = pressing_q;
    press_done_d   = press_done_q;
    clients_d      = clients_q;
    reason_d       = reason_q;
    retries_d      = retries_q;
    cmd_connect    = 1'b0;
    cmd_ap         = AP_NONE;
    refused        = 1'b0;

    case (item_i.func)
      FN_TICK: begin
        tick_d = tick_next;
        if (cfg_i.button_en && item_i.button_pressed) begin
          if (!pressing_q) begin
            pressing_d    = 1'b1;
            press_start_d = tick_next;
          end else if (!press_done_q &&
                       passed_f(tick_next, press_start_q, CW'(HOLD_MS))) begin
            press_done_d   = 1'b1;
            ap_on_d        = 1'b1;
            forced_d       = 1'b1;
            forced_until_d = tick_next + TW'(FORCE_MS);
            if (!ap_on_q) begin
              clients_d = 8'd0;
              cmd_ap    = AP_ON;
            end
          end
        end else begin
          pressing_d   = 1'b0;
          press_done_d = 1'b0;
        end
        if (!item_i.op_busy) begin
          if (creds_q && !link_q && !connecting_q && due_f(tick_next, next_retry_q)) begin
            connecting_d = 1'b1;
            cmd_connect  = 1'b1;
          end
          if (!ap_on_d && !link_q &&
              (!creds_q || passed_f(tick_next, down_since_q, CW'(cfg_i.delay_ms)))) begin
            ap_on_d   = 1'b1;
            clients_d = 8'd0;
            cmd_ap    = AP_ON;
          end
          if (ap_on_d && forced_d && due_f(tick_next, forced_until_d)) begin
            forced_d = 1'b0;
          end
          if (ap_on_d && !forced_d && link_q && clients_d == 8'd0 &&
              passed_f(tick_next, up_since_q, CW'(IDLE_OFF_MS))) begin
            ap_on_d   = 1'b0;
            forced_d  = 1'b0;
            clients_d = 8'd0;
            cmd_ap    = AP_OFF;
          end
        end
      end
      FN_LINK_LOST: begin
        reason_d = item_i.disconnect_reason;
        if (link_q) begin
          down_since_d = tick_q;
        end
        link_d       = 1'b0;
        connecting_d = 1'b0;
        retries_d    = retries_inc;
        next_retry_d = tick_q + wait_ms;
      end
      FN_GOT_ADDR: begin
        link_d       = 1'b1;
        connecting_d = 1'b0;
        retries_d    = 16'd0;
        reason_d     = 8'd0;
        up_since_d   = tick_q;
      end
      FN_CLIENT_JOIN: begin
        if (clients_q != 8'hFF) begin
          clients_d = clients_q + 8'd1;
        end
      end
      FN_CLIENT_LEAVE: begin
        if (clients_q != 8'd0) begin
          clients_d = clients_q - 8'd1;
        end
      end
      FN_REJECTED: begin
        connecting_d = 1'b0;
        next_retry_d = tick_q + TW'(REJECT_MS);
      end
      FN_CREDS: begin
        creds_d = item_i.creds_present;
      end
      FN_AP_REQ: begin
        if (item_i.ap_request_on) begin
          ap_on_d        = 1'b1;
          forced_d       = 1'b1;
          forced_until_d = tick_q + TW'(FORCE_MS);
          if (!ap_on_q) begin
            clients_d = 8'd0;
            cmd_ap    = AP_ON;
          end
        end else if (link_q) begin
          if (ap_on_q) begin
            ap_on_d   = 1'b0;
            forced_d  = 1'b0;
            clients_d = 8'd0;
            cmd_ap    = AP_OFF;
          end
        end else begin
          refused = 1'b1;
        end
      end
      default: begin
        cmd_ap = AP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q         <= '0;
      down_since_q   <= '0;
      up_since_q     <= '0;
      next_retry_q   <= '0;
      forced_until_q <= '0;
      press_start_q  <= '0;
      link_q         <= 1'b0;
      connecting_q   <= 1'b0;
      creds_q        <= 1'b0;
      ap_on_q        <= 1'b0;
      forced_q       <= 1'b0;
      pressing_q     <= 1'b0;
      press_done_q   <= 1'b0;
      clients_q      <= '0;
      reason_q       <= '0;
      retries_q      <= '0;
    end else if (step_i) begin
      tick_q         <= tick_d;
      down_since_q   <= down_since_d;
      up_since_q     <= up_since_d;
      next_retry_q   <= next_retry_d;
      forced_until_q <= forced_until_d;
      press_start_q  <= press_start_d;
      link_q         <= link_d;
      connecting_q   <= connecting_d;
      creds_q        <= creds_d;
      ap_on_q        <= ap_on_d;
      forced_q       <= forced_d;
      pressing_q     <= pressing_d;
      press_done_q   <= press_done_d;
      clients_q      <= clients_d;
      reason_q       <= reason_d;
      retries_q      <= retries_d;
    end
  end

  always_comb begin
    result_o.cmd_connect     = cmd_connect;
    result_o.cmd_ap          = cmd_ap;
    result_o.link_up         = link_d;
    result_o.ap_active       = ap_on_d;
    result_o.client_count    = clients_d;
    result_o.retry_count     = retries_d;
    result_o.drop_reason     = reason_d;
    result_o.request_refused = refused;
  end

endmodule

@@ rtl/core/lrs_out_stage.sv @@
// Result register: holds one result beat and packs it onto the master side.
module lrs_out_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  lrs_pkg::lrs_result_t           result_i,
  output logic                           space_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lrs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output lrs_pkg::lrs_result_t           result_o
);
  import lrs_pkg::*;

  logic        valid_q;
  lrs_result_t result_q;

  assign space_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {2'b00, result_q.request_refused, result_q.drop_reason,
                          result_q.retry_count, result_q.client_count, result_q.ap_active,
                          result_q.link_up, result_q.cmd_ap, result_q.cmd_connect};
  assign result_o      = result_q;

endmodule

@@ rtl/core/link_reconnect_supervisor.sv @@
// Top level of the link reconnect supervisor: config registers and stream stages.
//
//   port group   dir  beat fields (low bit first)
//   s_axis       in   tuser: func; tdata: button_pressed, op_busy, disconnect_reason,
//                     ap_request_on, creds_present
//   m_axis       out  tdata: cmd_connect, cmd_ap, link_up, ap_active, client_count,
//                     retry_count, drop_reason, request_refused
//   cfg          in   cfg_index_i 0 ap_delay_seconds, 1 button_enable; cfg_data_i
//
// Each beat is held in the input register and is decided in one pass by the core, which
// writes the result register; one beat per cycle is sustained while the master is ready.
// Reset clears all supervisor state; delay resets to 60 s, button sampling to enabled.
// A stalled master holds the result register; the input register takes one more beat
// and then holds s_axis_tready low until the result register frees up.
module link_reconnect_supervisor #(
  parameter int unsigned TIME_BITS = lrs_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // button_pressed, op_busy, disconnect_reason[7:0], ap_request_on, creds_present, pad
  input  logic [lrs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func[2:0]
  input  logic [lrs_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // cmd_connect, cmd_ap[1:0], link_up, ap_active, client_count[7:0], retry_count[15:0],
  // drop_reason[7:0], request_refused, pad
  output logic [lrs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lrs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lrs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lrs_pkg::*;

  lrs_cfg_t    cfg_q;
  lrs_item_t   item;
  lrs_result_t result;
  lrs_result_t out_q;
  logic        in_valid;
  logic        out_space;
  logic        step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_ms  <= DELAY_MS_W'(AP_DELAY_RST * MS_PER_S);
      cfg_q.button_en <= 1'b1;
    end else if (cfg_valid_i) begin
      case (lrs_cfg_idx_e'(cfg_index_i))
        CFG_AP_DELAY:  cfg_q.delay_ms  <= DELAY_MS_W'(cfg_data_i) * DELAY_MS_W'(MS_PER_S);
        CFG_BUTTON_EN: cfg_q.button_en <= cfg_data_i[0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  assign step = in_valid && out_space;

  lrs_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take_i        (step),
    .valid_o       (in_valid),
    .item_o        (item)
  );

  lrs_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  lrs_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (step),
    .result_i      (result),
    .space_o       (out_space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .result_o      (out_q)
  );

  a_cmd_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.cmd_ap == AP_NONE || out_q.cmd_ap == AP_ON ||
                       out_q.cmd_ap == AP_OFF))
    else $error("invalid AP command code");

  a_refuse_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.request_refused) |-> (!out_q.link_up && out_q.cmd_ap == AP_NONE))
    else $error("AP off refused while link up or with AP change");

  a_ap_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.cmd_ap == AP_OFF) |->
      (!out_q.ap_active && out_q.client_count == 8'd0 && out_q.link_up))
    else $error("AP off result inconsistent");

  a_ap_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.cmd_ap == AP_ON) |-> (out_q.ap_active && out_q.client_count == 8'd0))
    else $error("AP on result inconsistent");

  a_connect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.cmd_connect) |-> !out_q.link_up)
    else $error("connect issued while link up");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the link reconnect supervisor stream block.
`timescale 1ns / 1ps

module tb;
  import lrs_pkg::*;

  localparam int unsigned TICK_MS         = 100;
  localparam int unsigned HOLD_TO_FORCE   = 3000;
  localparam int unsigned FORCE_WINDOW_MS = 600000;
  localparam int unsigned IDLE_DROP_MS    = 30000;
  localparam int unsigned RETRY_SHORT_MS  = 1000;
  localparam int unsigned RETRY_MID_MS    = 5000;
  localparam int unsigned RETRY_LONG_MS   = 15000;
  localparam int unsigned REJECT_WAIT_MS  = 1000;
  localparam int unsigned IDLE_PCT        = 37;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned STALL_CYCLES    = 80;
  localparam int unsigned RANDOM_EVENTS   = 180;
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned RES_W           = $bits(lrs_result_t);

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  link_reconnect_supervisor i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // supervisor state as predicted
  logic [31:0] now_ms        = '0;
  logic [31:0] down_ms       = '0;
  logic [31:0] up_ms         = '0;
  logic [31:0] retry_at_ms   = '0;
  logic [31:0] forced_end_ms = '0;
  logic [31:0] press_ms      = '0;
  logic        link_m        = 1'b0;
  logic        connecting_m  = 1'b0;
  logic        creds_m       = 1'b0;
  logic        ap_m          = 1'b0;
  logic        forced_m      = 1'b0;
  logic        pressing_m    = 1'b0;
  logic        press_done_m  = 1'b0;
  logic [7:0]  clients_m     = '0;
  logic [15:0] retries_m     = '0;
  logic [7:0]  reason_m      = '0;
  logic [11:0] delay_s       = 12'd60;
  logic        button_en     = 1'b1;

  lrs_result_t expected_q[$];
  lrs_result_t got, want;
  int unsigned errors     = 0;
  int unsigned events_in  = 0;
  int unsigned results    = 0;
  int unsigned connects   = 0;
  int unsigned ap_ons     = 0;
  int unsigned ap_offs    = 0;
  int unsigned refusals   = 0;
  int unsigned cycles     = 0;
  int unsigned hold_reqs  = 0;
  bit          steady     = 1'b0;
  bit          btn_held   = 1'b0;

  function automatic logic elapsed(logic [31:0] since, logic [31:0] span);
    logic [31:0] d;
    d = now_ms - since;
    return d >= span;
  endfunction

  function automatic logic reached(logic [31:0] deadline);
    logic [31:0] d;
    d = now_ms - deadline;
    return ~d[31];
  endfunction

  function automatic lrs_ap_cmd_e ap_up(logic forced);
    lrs_ap_cmd_e c;
    c = AP_NONE;
    if (!ap_m) begin
      ap_m = 1'b1;
      clients_m = '0;
      c = AP_ON;
    end
    if (forced) begin
      forced_m = 1'b1;
      forced_end_ms = now_ms + FORCE_WINDOW_MS;
    end
    return c;
  endfunction

  function automatic lrs_ap_cmd_e ap_down();
    if (!ap_m) return AP_NONE;
    ap_m = 1'b0;
    forced_m = 1'b0;
    clients_m = '0;
    return AP_OFF;
  endfunction

  function automatic lrs_result_t supervise(lrs_func_e f, logic btn, logic busy,
                                            logic [7:0] why, logic req_on, logic creds);
    lrs_result_t r;
    logic        connect;
    logic        refused;
    lrs_ap_cmd_e ap;
    logic [31:0] backoff;
    connect = 1'b0;
    refused = 1'b0;
    ap = AP_NONE;
    case (f)
      FN_TICK: begin
        now_ms = now_ms + TICK_MS;
        if (button_en && btn) begin
          if (!pressing_m) begin
            pressing_m = 1'b1;
            press_ms = now_ms;
          end else if (!press_done_m && elapsed(press_ms, HOLD_TO_FORCE)) begin
            press_done_m = 1'b1;
            ap = ap_up(1'b1);
          end
        end else begin
          pressing_m = 1'b0;
          press_done_m = 1'b0;
        end
        if (!busy) begin
          if (creds_m && !link_m && !connecting_m && reached(retry_at_ms)) begin
            connecting_m = 1'b1;
            connect = 1'b1;
          end
          if (!ap_m && !link_m && (!creds_m || elapsed(down_ms, 32'(delay_s) * 32'd1000)))
            ap = ap_up(1'b0);
          if (ap_m && forced_m && reached(forced_end_ms))
            forced_m = 1'b0;
          if (ap_m && !forced_m && link_m && clients_m == 0 && elapsed(up_ms, IDLE_DROP_MS))
            ap = ap_down();
        end
      end
      FN_LINK_LOST: begin
        reason_m = why;
        if (link_m) down_ms = now_ms;
        link_m = 1'b0;
        connecting_m = 1'b0;
        if (retries_m != 16'hFFFF) retries_m = retries_m + 16'd1;
        backoff = retries_m <= 5 ? RETRY_SHORT_MS :
                  (retries_m <= 10 ? RETRY_MID_MS : RETRY_LONG_MS);
        retry_at_ms = now_ms + backoff;
      end
      FN_GOT_ADDR: begin
        link_m = 1'b1;
        connecting_m = 1'b0;
        retries_m = '0;
        reason_m = '0;
        up_ms = now_ms;
      end
      FN_CLIENT_JOIN: if (clients_m != 8'hFF) clients_m = clients_m + 8'd1;
      FN_CLIENT_LEAVE: if (clients_m != 0) clients_m = clients_m - 8'd1;
      FN_REJECTED: begin
        connecting_m = 1'b0;
        retry_at_ms = now_ms + REJECT_WAIT_MS;
      end
      FN_CREDS: creds_m = creds;
      default: begin
        if (req_on) ap = ap_up(1'b1);
        else if (link_m) ap = ap_down();
        else refused = 1'b1;
      end
    endcase
    r.cmd_connect     = connect;
    r.cmd_ap          = ap;
    r.link_up         = link_m;
    r.ap_active       = ap_m;
    r.client_count    = clients_m;
    r.retry_count     = retries_m;
    r.drop_reason     = reason_m;
    r.request_refused = refused;
    return r;
  endfunction

  task automatic send_event(lrs_func_e f, logic btn = 1'b0, logic busy = 1'b0,
                            logic [7:0] why = '0, logic req_on = 1'b0,
                            logic creds = 1'b0);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {4'b0000, creds, req_on, why, busy, btn};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(supervise(f, btn, busy, why, req_on, creds));
    events_in++;
  endtask

  task automatic tick(logic btn = 1'b0, logic busy = 1'b0);
    send_event(FN_TICK, btn, busy, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic send_random();
    int unsigned    pick;
    lrs_func_e      f;
    logic           btn;
    logic           busy;
    pick = $urandom_range(99);
    btn  = 1'($urandom);
    busy = 1'($urandom);
    if (pick < 50) f = FN_TICK;
    else if (pick < 58) f = FN_LINK_LOST;
    else if (pick < 66) f = FN_GOT_ADDR;
    else if (pick < 73) f = FN_CLIENT_JOIN;
    else if (pick < 80) f = FN_CLIENT_LEAVE;
    else if (pick < 85) f = FN_REJECTED;
    else if (pick < 92) f = FN_CREDS;
    else f = FN_AP_REQ;
    if (f == FN_TICK) begin
      if ($urandom_range(99) < 4) btn_held = ~btn_held;
      btn  = btn_held;
      busy = $urandom_range(99) < 15;
    end
    send_event(f, btn, busy, 8'($urandom), 1'($urandom),
               $urandom_range(99) < 75);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(lrs_cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_AP_DELAY) delay_s = val;
    else button_en = val[0];
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [11:0] delay, logic en);
    drain();
    write_reg(CFG_AP_DELAY, delay);
    write_reg(CFG_BUTTON_EN, CFG_DATA_W'(en));
  endtask

  task automatic test_directed();
    tick();
    send_event(FN_CLIENT_JOIN);
    send_event(FN_CLIENT_LEAVE);
    send_event(FN_CLIENT_LEAVE);
    send_event(FN_AP_REQ, .req_on(1'b0));
    send_event(FN_CREDS, .creds(1'b1));
    send_event(FN_LINK_LOST, .why(8'hFF));
    send_event(FN_LINK_LOST, .why(8'h00));
    send_event(FN_REJECTED);
    tick(1'b1, 1'b1);
    send_event(FN_GOT_ADDR);
    send_event(FN_AP_REQ, .req_on(1'b0));
    send_event(FN_AP_REQ, .req_on(1'b0));
    send_event(FN_AP_REQ, .req_on(1'b1));
    send_event(FN_AP_REQ, .req_on(1'b1));
    send_event(FN_LINK_LOST, .why(8'hA5));
    send_event(FN_CREDS, .creds(1'b0));
    tick();
    tick(1'b0, 1'b1);
    send_event(FN_GOT_ADDR);
  endtask

  // link down with credentials: AP after the configured delay
  task automatic test_ap_delay();
    logic [11:0] delays[3];
    delays = '{12'd0, 12'd3600, 12'd2};
    foreach (delays[i]) begin
      set_config(delays[i], 1'b1);
      send_event(FN_CREDS, .creds(1'b1));
      send_event(FN_GOT_ADDR);
      send_event(FN_AP_REQ, .req_on(1'b0));
      send_event(FN_LINK_LOST, .why(8'($urandom)));
      repeat (22) tick();
    end
    set_config(12'd60, 1'b1);
  endtask

  task automatic test_button_hold();
    send_event(FN_GOT_ADDR);
    send_event(FN_AP_REQ, .req_on(1'b0));
    repeat (35) tick(1'b1, $urandom_range(99) < 20);
    tick();
    repeat (32) tick(1'b1);
    set_config(12'd60, 1'b0);
    repeat (10) tick(1'b1);
    set_config(12'd60, 1'b1);
    repeat (3) tick();
  endtask

  task automatic test_reconnect();
    send_event(FN_CREDS, .creds(1'b1));
    send_event(FN_GOT_ADDR);
    send_event(FN_LINK_LOST, .why(8'd15));
    repeat (12) tick();
    send_event(FN_REJECTED);
    repeat (12) tick();
    for (int r = 0; r < 12; r++) begin
      send_event(FN_LINK_LOST, .why(8'($urandom)));
      repeat (r < 5 ? 12 : (r == 5 ? 52 : (r == 11 ? 152 : 3)))
        tick(1'b0, $urandom_range(99) < 5);
    end
    send_event(FN_GOT_ADDR);
  endtask

  task automatic test_idle_drop();
    send_event(FN_CREDS, .creds(1'b0));
    send_event(FN_LINK_LOST, .why(8'd2));
    tick();
    send_event(FN_GOT_ADDR);
    send_event(FN_CLIENT_JOIN);
    repeat (310) tick();
    send_event(FN_CLIENT_LEAVE);
    repeat (2) tick();
  endtask

  // forced AP requests with the link up, then ticks inside the forced window
  task automatic test_forced_window();
    send_event(FN_GOT_ADDR);
    send_event(FN_AP_REQ, .req_on(1'b1));
    repeat (50) tick();
    send_event(FN_AP_REQ, .req_on(1'b1));
    repeat (40) tick(1'b0, $urandom_range(99) < 3);
  endtask

  task automatic test_client_saturation();
    repeat (258) send_event(FN_CLIENT_JOIN);
    repeat (4) send_event(FN_CLIENT_LEAVE);
  endtask

  // both sides run without idling here
  task automatic test_steady_stream();
    drain();
    steady = 1'b1;
    repeat (60) send_event(FN_LINK_LOST, .why(8'($urandom)));
    send_event(FN_GOT_ADDR);
    drain();
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    drain();
    hold_reqs++;
    repeat (40) send_random();
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: set_config(12'($urandom_range(5)), 1'b1);
        1: set_config(12'd0, 1'b0);
        default: set_config(12'($urandom_range(3, 1)), 1'b1);
      endcase
      repeat (RANDOM_EVENTS / 3) send_random();
    end
  endtask

  initial begin : receiver
    int unsigned seen = 0;
    int unsigned stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = lrs_result_t'(m_axis_tdata[RES_W-1:0]);
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
      end else begin
        want = expected_q.pop_front();
        results++;
        connects += 32'(want.cmd_connect);
        ap_ons   += 32'(want.cmd_ap == AP_ON);
        ap_offs  += 32'(want.cmd_ap == AP_OFF);
        refusals += 32'(want.request_refused);
        check_field("cmd_connect", 32'(want.cmd_connect), 32'(got.cmd_connect));
        check_field("cmd_ap", 32'(want.cmd_ap), 32'(got.cmd_ap));
        check_field("link_up", 32'(want.link_up), 32'(got.link_up));
        check_field("ap_active", 32'(want.ap_active), 32'(got.ap_active));
        check_field("client_count", 32'(want.client_count), 32'(got.client_count));
        check_field("retry_count", 32'(want.retry_count), 32'(got.retry_count));
        check_field("drop_reason", 32'(want.drop_reason), 32'(got.drop_reason));
        check_field("request_refused", 32'(want.request_refused),
                    32'(got.request_refused));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_ap_delay();
    test_button_hold();
    test_reconnect();
    test_idle_drop();
    test_forced_window();
    test_client_saturation();
    test_steady_stream();
    test_backpressure();
    test_random();
    drain();
    $display("covered %0d events and %0d result beats over %0d cycles", events_in,
             results, cycles);
    $display("connects %0d, AP on %0d, AP off %0d, refused requests %0d", connects,
             ap_ons, ap_offs, refusals);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
